[hdl/wkt_pkg.sv]
// Package for the worked-key table: widths, op codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package wkt_pkg;
	localparam int TableDepth = 1024;
	localparam int NumBands   = 11;
	localparam int KeyChars   = 5;
	localparam int KeyW       = 8 * KeyChars;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int CntW       = $clog2(TableDepth + 1);
	localparam int PairW      = 14;
	localparam int BandW      = 4;
	localparam int OpW        = 2;
	// cells in the search chain; each owns one stripe of entries
	localparam int NumCells   = 4;
	localparam int CellDepth  = TableDepth / NumCells;
	localparam int CellIdxW   = $clog2(CellDepth);
	localparam int CellSelW   = $clog2(NumCells);

	typedef enum logic [OpW-1:0] {
		OP_ADD   = 2'd0,
		OP_PROBE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [OpW-1:0]    op;
		logic [KeyW-1:0]   key;
		logic [BandW-1:0]  band;
	} req_t;

	typedef struct packed {
		logic              key_found;
		logic              band_found;
		logic              add_answer;
		logic              table_full;
		logic [CntW-1:0]   distinct_count;
		logic [PairW-1:0]  pair_count;
		logic [CntW-1:0]   band_count;
	} rsp_t;

	// per-cell scan control
	typedef struct packed {
		logic              scan;
		logic [CellIdxW-1:0] addr;
		logic [KeyW-1:0]   key;
	} cell_cmd_t;

	// per-cell write control
	typedef struct packed {
		logic              we;
		logic [CellIdxW-1:0] addr;
		logic [KeyW-1:0]   key;
		logic [NumBands-1:0] mask;
	} cell_wr_t;

	// hit status handed down the chain
	typedef struct packed {
		logic              hit;
		logic [IdxW-1:0]   idx;
		logic [NumBands-1:0] mask;
	} hit_t;

	function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] raw);
		logic [KeyW-1:0] r;
		logic            stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < KeyChars; i++) begin
			if (raw[KeyW-1-8*i -: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[KeyW-1-8*i -: 8] = raw[KeyW-1-8*i -: 8];
		end
		return r;
	endfunction
endpackage

[hdl/wkt_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on wkt_pkg for the req_t and rsp_t payload types.
`timescale 1ns / 1ps
interface wkt_req_if import wkt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface wkt_rsp_if import wkt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/wkt_cell.sv]
// One search cell: a stripe of the key and mask memories plus a compare stage.
// Takes the hit status from its upstream neighbor and passes it on. Uses wkt_pkg.
`timescale 1ns / 1ps
module wkt_cell import wkt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CellSelW-1:0] cell_id,
	input  cell_cmd_t           cmd,
	input  cell_wr_t            wr,
	input  logic [CntW-1:0]     fill,
	input  hit_t                hit_in,
	output hit_t                hit_out
);
	logic [KeyW-1:0]     key_mem  [CellDepth];
	logic [NumBands-1:0] mask_mem [CellDepth];
	logic [KeyW-1:0]     rd_key_s1;
	logic [NumBands-1:0] rd_mask_s1;
	logic [KeyW-1:0]     cmp_key_s1;
	logic [IdxW-1:0]     idx_s1;
	logic                scan_s1;
	logic [IdxW-1:0]     idx_now;
	logic                live;

	always_ff @(posedge clk) begin
		if (wr.we)
			key_mem[wr.addr] <= wr.key;
		if (wr.we)
			mask_mem[wr.addr] <= wr.mask;
		rd_key_s1  <= key_mem[cmd.addr];
		rd_mask_s1 <= mask_mem[cmd.addr];
		cmp_key_s1 <= cmd.key;
		idx_s1     <= idx_now;
	end

	// entry index: stripe address times cell count plus cell number
	assign idx_now = {cmd.addr, cell_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			hit_out <= '0;
		end else begin
			scan_s1 <= cmd.scan;
			// first hit in insertion order wins: keep upstream hit
			if (hit_in.hit)
				hit_out <= hit_in;
			else if (live && rd_key_s1 == cmp_key_s1)
				hit_out <= '{hit: 1'b1, idx: idx_s1, mask: rd_mask_s1};
			else
				hit_out <= '0;
		end
	end

	assign live = scan_s1 && ({1'b0, idx_s1} < fill);
endmodule

[hdl/worked_key_table_with_band_mask.sv]
// Channel  | dir | payload
// req      | in  | op, key, band
// rsp      | out | key_found, band_found, add_answer, table_full, counts
// cfg      | in  | cfg_we, cfg_data -> per_band_mode
// An add or probe presents its response after the scan, write and output states: each
// cell scans one memory row per cycle and hits ripple down the cell chain. A clear skips
// the scan and write states and presents its response after the output state.
// The next request is taken only once the response has been accepted.
// Reset empties the table and counters at once; stored entries need no clearing pass.
// A result held on a stalled rsp blocks the next request until taken.
// Depends on wkt_pkg, wkt_if, wkt_cell.
`timescale 1ns / 1ps
module worked_key_table_with_band_mask import wkt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	wkt_req_if.sink    req,
	wkt_rsp_if.source  rsp
);
	state_t state_q, state_d;
	logic                per_band_mode_q;
	req_t                cur_q;
	logic [CntW-1:0]     fill_q;
	logic [PairW-1:0]    pair_q;
	logic [CntW-1:0]     band_cnt_q [NumBands];
	logic [CellIdxW:0]   step_q;
	hit_t                hit_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	cell_cmd_t           cmd;
	cell_wr_t            wr [NumCells];
	hit_t                chain [NumCells+1];
	logic                band_ok;
	logic                scan_done;

	assign band_ok = {1'b0, cur_q.band} < (BandW+1)'(NumBands);
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			per_band_mode_q <= 1'b0;
		else if (cfg_we)
			per_band_mode_q <= cfg_data;
	end

	assign cmd.scan = (state_q == ST_SCAN) && !step_q[CellIdxW];
	assign cmd.addr = step_q[CellIdxW-1:0];
	assign cmd.key  = cur_q.key;
	assign chain[0] = '0;

	for (genvar c = 0; c < NumCells; c++) begin : g_cell
		always_comb begin
			wr[c].we   = 1'b0;
			wr[c].addr = '0;
			wr[c].key  = cur_q.key;
			wr[c].mask = '0;
			if (state_q == ST_WRITE && cur_q.op == OP_ADD && band_ok) begin
				if (hit_q.hit) begin
					wr[c].we   = (hit_q.idx[CellSelW-1:0] == CellSelW'(c))
						&& !hit_q.mask[cur_q.band];
					wr[c].addr = hit_q.idx[IdxW-1:CellSelW];
					wr[c].mask = hit_q.mask | (NumBands'(1) << cur_q.band);
				end else if (fill_q < CntW'(TableDepth)) begin
					wr[c].we   = (fill_q[CellSelW-1:0] == CellSelW'(c));
					wr[c].addr = fill_q[IdxW-1:CellSelW];
					wr[c].mask = NumBands'(1) << cur_q.band;
				end
			end
		end
		wkt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (CellSelW'(c)),
			.cmd     (cmd),
			.wr      (wr[c]),
			.fill    (fill_q),
			.hit_in  (chain[c]),
			.hit_out (chain[c+1])
		);
	end

	// scan issues CellDepth rows, then waits while the last rows drain down the cell chain
	assign scan_done = step_q == (CellIdxW+1)'(CellDepth + NumCells + 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid && req.ready)
					state_d = (req.data.op == OP_CLEAR) ? ST_OUT : ST_SCAN;
			end
			ST_SCAN:  if (scan_done) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			fill_q      <= '0;
			pair_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			hit_q       <= '0;
			for (int b = 0; b < NumBands; b++)
				band_cnt_q[b] <= '0;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					hit_q  <= '0;
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					// hold the first hit seen at the chain end
					if (chain[NumCells].hit && !hit_q.hit)
						hit_q <= chain[NumCells];
				end
				ST_WRITE: begin
					rsp_q.key_found  <= hit_q.hit;
					rsp_q.band_found <= hit_q.hit && band_ok && hit_q.mask[cur_q.band];
					rsp_q.add_answer <= per_band_mode_q
						? (hit_q.hit && band_ok && hit_q.mask[cur_q.band]) : hit_q.hit;
					rsp_q.table_full <= 1'b0;
					if (cur_q.op == OP_ADD && band_ok) begin
						if (hit_q.hit) begin
							if (!hit_q.mask[cur_q.band]) begin
								pair_q <= pair_q + 1'b1;
								band_cnt_q[cur_q.band] <= band_cnt_q[cur_q.band] + 1'b1;
							end
						end else if (fill_q >= CntW'(TableDepth)) begin
							rsp_q.table_full <= 1'b1;
						end else begin
							fill_q <= fill_q + 1'b1;
							pair_q <= pair_q + 1'b1;
							band_cnt_q[cur_q.band] <= band_cnt_q[cur_q.band] + 1'b1;
						end
					end
				end
				ST_OUT: begin
					rsp_valid_q <= 1'b1;
					if (cur_q.op == OP_CLEAR) begin
						rsp_q <= '0;
						fill_q <= '0;
						pair_q <= '0;
						for (int b = 0; b < NumBands; b++)
							band_cnt_q[b] <= '0;
					end else begin
						rsp_q.distinct_count <= fill_q;
						rsp_q.pair_count     <= pair_q;
						rsp_q.band_count     <= band_ok ? band_cnt_q[cur_q.band] : '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cur_q.op   <= req.data.op;
			cur_q.key  <= norm_key(req.data.key);
			cur_q.band <= req.data.band;
		end
	end
endmodule
